[sv/fba_pkg.sv]
// Shared constants, types and codes for the frame bitmap allocator.
package fba_pkg;

  localparam int NUM_FRAMES = 4096;
  localparam int FRAME_W    = 12;
  localparam int WORD_BITS  = 32;
  localparam int BIT_AW     = $clog2(WORD_BITS);
  localparam int BM_WORDS   = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW    = (BM_WORDS > 1) ? $clog2(BM_WORDS) : 1;

  typedef logic [FRAME_W-1:0]   frame_t;
  typedef logic [WORD_AW-1:0]   waddr_t;
  typedef logic [WORD_BITS-1:0] bm_word_t;
  typedef logic [BIT_AW-1:0]    bidx_t;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_MARK  = 2'd2,
    OP_TEST  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_SKIP = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // Lowest clear bit of a bitmap word; only meaningful when one exists.
  function automatic bidx_t first_zero(input bm_word_t w);
    bidx_t idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) idx = bidx_t'(i);
    end
    return idx;
  endfunction

endpackage

[sv/frame_bitmap_allocator_top.sv]
// Top level: first-fit frame allocator over a used/free bitmap held in RAM.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+--------------------------------------------
//  in_     | in  | in_valid / in_ready    | op, frame_number, kernel_req, write_req
//  out_    | out | out_valid / out_ready  | status, result_frame, present, writable,
//          |     |                        | user_mode, is_used
//
// Free, mark, test and a skipped allocate do one RAM read; a free of a nonzero
// frame and a mark then modify and write back the word. A first-fit allocate
// reads one bitmap word a cycle from word 0 upward until it finds a free frame.
// Reset clears a per-word valid vector; an unwritten word reads as all free,
// so no clearing pass is needed. One request is in flight at a time; a beat
// waiting on out_ stalls only the end of the next request, not its start.
module frame_bitmap_allocator_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_op,
  input  logic [fba_pkg::FRAME_W-1:0]   in_frame_number,
  input  logic                          in_kernel_req,
  input  logic                          in_write_req,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [fba_pkg::FRAME_W-1:0]   out_result_frame,
  output logic                          out_present,
  output logic                          out_writable,
  output logic                          out_user_mode,
  output logic                          out_is_used
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACCESS,
    S_SCAN
  } state_t;

  state_t state_r, state_nxt;

  logic [1:0]        op_r, op_nxt;
  fba_pkg::frame_t   frame_r, frame_nxt;
  logic              kern_r, kern_nxt;
  logic              wrq_r, wrq_nxt;
  fba_pkg::waddr_t   scan_addr_r, scan_addr_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  fba_pkg::frame_t   out_frame_r, out_frame_nxt;
  logic              out_present_r, out_present_nxt;
  logic              out_writable_r, out_writable_nxt;
  logic              out_user_r, out_user_nxt;
  logic              out_used_r, out_used_nxt;

  // bitmap RAM and per-word valid bits
  fba_pkg::bm_word_t           bm_mem [fba_pkg::BM_WORDS];
  logic [fba_pkg::BM_WORDS-1:0] vld_r;
  fba_pkg::bm_word_t           rd_data_r;
  logic                        rd_vld_r;
  logic                        rd_en;
  fba_pkg::waddr_t             rd_addr;
  logic                        wr_en;
  fba_pkg::waddr_t             wr_addr;
  fba_pkg::bm_word_t           wr_data;

  logic              in_fire;
  logic              out_free;
  fba_pkg::bm_word_t cur_word;
  fba_pkg::bm_word_t bit_mask;
  logic              frame_ok;
  logic              word_full;
  fba_pkg::bidx_t    zero_idx;
  logic              cand_ok;
  logic              last_word;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign cur_word  = rd_vld_r ? rd_data_r : '0;
  assign bit_mask  = fba_pkg::bm_word_t'(1) << frame_r[fba_pkg::BIT_AW-1:0];
  assign frame_ok  = 32'(frame_r) < 32'(fba_pkg::NUM_FRAMES);
  assign word_full = &cur_word;
  assign zero_idx  = fba_pkg::first_zero(cur_word);
  assign cand_ok   = !word_full &&
                     (32'({scan_addr_r, zero_idx}) < 32'(fba_pkg::NUM_FRAMES));
  assign last_word = (scan_addr_r == fba_pkg::waddr_t'(fba_pkg::BM_WORDS - 1));

  always_comb begin
    state_nxt        = state_r;
    op_nxt           = op_r;
    frame_nxt        = frame_r;
    kern_nxt         = kern_r;
    wrq_nxt          = wrq_r;
    scan_addr_nxt    = scan_addr_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_status_nxt   = out_status_r;
    out_frame_nxt    = out_frame_r;
    out_present_nxt  = out_present_r;
    out_writable_nxt = out_writable_r;
    out_user_nxt     = out_user_r;
    out_used_nxt     = out_used_r;
    rd_en            = 1'b0;
    rd_addr          = fba_pkg::waddr_t'(in_frame_number >> fba_pkg::BIT_AW);
    wr_en            = 1'b0;
    wr_addr          = fba_pkg::waddr_t'(frame_r >> fba_pkg::BIT_AW);
    wr_data          = cur_word;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt    = in_op;
          frame_nxt = in_frame_number;
          kern_nxt  = in_kernel_req;
          wrq_nxt   = in_write_req;
          rd_en     = 1'b1;
          if (in_op == fba_pkg::OP_ALLOC && in_frame_number == '0) begin
            rd_addr       = '0;
            scan_addr_nxt = '0;
            state_nxt     = S_SCAN;
          end else begin
            state_nxt = S_ACCESS;
          end
        end
      end

      S_ACCESS: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_status_nxt   = fba_pkg::ST_DONE;
          out_frame_nxt    = '0;
          out_present_nxt  = 1'b0;
          out_writable_nxt = 1'b0;
          out_user_nxt     = 1'b0;
          out_used_nxt     = 1'b0;
          case (op_r)
            fba_pkg::OP_ALLOC: begin
              // only a request with a frame already mapped lands here
              out_status_nxt = fba_pkg::ST_SKIP;
            end
            fba_pkg::OP_FREE: begin
              if (frame_r == '0) begin
                out_status_nxt = fba_pkg::ST_SKIP;
              end else begin
                wr_en   = frame_ok;
                wr_data = cur_word & ~bit_mask;
              end
            end
            fba_pkg::OP_MARK: begin
              wr_en   = frame_ok;
              wr_data = cur_word | bit_mask;
            end
            default: begin
              out_used_nxt = frame_ok && ((cur_word & bit_mask) != '0);
            end
          endcase
          state_nxt = S_IDLE;
        end
      end

      S_SCAN: begin
        if (cand_ok) begin
          if (out_free) begin
            wr_en            = 1'b1;
            wr_addr          = scan_addr_r;
            wr_data          = cur_word | (fba_pkg::bm_word_t'(1) << zero_idx);
            out_valid_nxt    = 1'b1;
            out_status_nxt   = fba_pkg::ST_DONE;
            out_frame_nxt    = fba_pkg::frame_t'({scan_addr_r, zero_idx});
            out_present_nxt  = 1'b1;
            out_writable_nxt = wrq_r;
            out_user_nxt     = !kern_r;
            out_used_nxt     = 1'b0;
            state_nxt        = S_IDLE;
          end
        end else if (!word_full || last_word) begin
          // free bit lies past the last frame, or every word is full
          if (out_free) begin
            out_valid_nxt    = 1'b1;
            out_status_nxt   = fba_pkg::ST_FULL;
            out_frame_nxt    = '0;
            out_present_nxt  = 1'b0;
            out_writable_nxt = 1'b0;
            out_user_nxt     = 1'b0;
            out_used_nxt     = 1'b0;
            state_nxt        = S_IDLE;
          end
        end else begin
          rd_en         = 1'b1;
          rd_addr       = scan_addr_r + fba_pkg::waddr_t'(1);
          scan_addr_nxt = scan_addr_r + fba_pkg::waddr_t'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r           <= op_nxt;
    frame_r        <= frame_nxt;
    kern_r         <= kern_nxt;
    wrq_r          <= wrq_nxt;
    scan_addr_r    <= scan_addr_nxt;
    out_status_r   <= out_status_nxt;
    out_frame_r    <= out_frame_nxt;
    out_present_r  <= out_present_nxt;
    out_writable_r <= out_writable_nxt;
    out_user_r     <= out_user_nxt;
    out_used_r     <= out_used_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bm_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= bm_mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_frame = out_frame_r;
  assign out_present      = out_present_r;
  assign out_writable     = out_writable_r;
  assign out_user_mode    = out_user_r;
  assign out_is_used      = out_used_r;

  // bitmap is only written while a request is being finished
  a_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r != S_IDLE) && out_free)
    else $error("bitmap write outside request completion");

  // an accepted beat always moves the controller out of idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != S_IDLE))
    else $error("request accepted but controller stayed idle");

  // finishing a request leaves a result beat pending
  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) && (state_nxt == S_IDLE) |=> out_valid_r)
    else $error("request finished without a result beat");

  // the bitmap is never written while a result beat is still waiting
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !wr_en)
    else $error("completion while output beat stalled");

endmodule

[sim/testbench.sv]
// Self-checking testbench for the first-fit frame bitmap allocator.
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int DRAIN_CYCLES = 150;

  typedef struct packed {
    fba_pkg::op_t    op;
    fba_pkg::frame_t frame;
    logic            kernel;
    logic            write;
  } request_t;

  typedef struct packed {
    fba_pkg::status_t status;
    fba_pkg::frame_t  frame;
    logic             present;
    logic             writable;
    logic             user_mode;
    logic             is_used;
  } outcome_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [1:0]                   in_op = '0;
  logic [fba_pkg::FRAME_W-1:0]  in_frame_number = '0;
  logic                         in_kernel_req = 1'b0;
  logic                         in_write_req = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [1:0]                   out_status;
  logic [fba_pkg::FRAME_W-1:0]  out_result_frame;
  logic                         out_present;
  logic                         out_writable;
  logic                         out_user_mode;
  logic                         out_is_used;

  request_t request_q[$];
  outcome_t outcome_q[$];
  bit       frame_used [fba_pkg::NUM_FRAMES];

  int requests_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int grants = 0;
  int skips = 0;
  int refusals = 0;
  int hold_cycles = 0;
  bit hold_done = 1'b0;
  int cycle_count = 0;

  frame_bitmap_allocator_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_frame_number  (in_frame_number),
    .in_kernel_req    (in_kernel_req),
    .in_write_req     (in_write_req),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_result_frame (out_result_frame),
    .out_present      (out_present),
    .out_writable     (out_writable),
    .out_user_mode    (out_user_mode),
    .out_is_used      (out_is_used)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one request to the shadow bitmap and gives the result it should produce.
  function automatic outcome_t allocator_outcome(request_t r);
    outcome_t o;
    int       found;
    o = '0;
    o.status = fba_pkg::ST_DONE;
    case (r.op)
      fba_pkg::OP_ALLOC: begin
        if (r.frame != 0) begin
          o.status = fba_pkg::ST_SKIP;
          skips++;
        end else begin
          found = -1;
          for (int i = 0; i < fba_pkg::NUM_FRAMES && found < 0; i++)
            if (!frame_used[i]) found = i;
          if (found < 0) begin
            o.status = fba_pkg::ST_FULL;
            refusals++;
          end else begin
            frame_used[found] = 1'b1;
            o.frame     = fba_pkg::frame_t'(found);
            o.present   = 1'b1;
            o.writable  = r.write;
            o.user_mode = !r.kernel;
            grants++;
          end
        end
      end
      fba_pkg::OP_FREE: begin
        if (r.frame == 0) begin
          o.status = fba_pkg::ST_SKIP;
          skips++;
        end else begin
          frame_used[r.frame] = 1'b0;
        end
      end
      fba_pkg::OP_MARK: frame_used[r.frame] = 1'b1;
      default: o.is_used = frame_used[r.frame];
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic void add_request(fba_pkg::op_t op, int frame, int kernel, int write);
    request_t r;
    r.op     = op;
    r.frame  = fba_pkg::frame_t'(frame);
    r.kernel = kernel[0];
    r.write  = write[0];
    request_q.push_back(r);
  endfunction

  // Driver: offers queued requests, predicting each one as it is accepted.
  always @(posedge clk) begin
    request_t r;
    request_t nxt;
    bit       idle;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        r.op     = fba_pkg::op_t'(in_op);
        r.frame  = in_frame_number;
        r.kernel = in_kernel_req;
        r.write  = in_write_req;
        outcome_q.push_back(allocator_outcome(r));
        requests_sent <= requests_sent + 1;
      end
      if (!in_valid || in_ready) begin
        // no idling on this side while requests 150..299 go through
        idle = !(requests_sent >= 150 && requests_sent < 300) && ($urandom_range(99) < 27);
        if (!idle && request_q.size() > 0) begin
          nxt = request_q.pop_front();
          in_op           <= nxt.op;
          in_frame_number <= nxt.frame;
          in_kernel_req   <= nxt.kernel;
          in_write_req    <= nxt.write;
          in_valid        <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat against the oldest prediction.
  always @(posedge clk) begin
    outcome_t want;
    bit       idle;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (outcome_q.size() == 0) begin
          report_mismatch("unexpected beat, pending count", 1, 0);
        end else begin
          want = outcome_q.pop_front();
          if (out_status != want.status)
            report_mismatch("status", 32'(out_status), 32'(want.status));
          if (out_result_frame != want.frame)
            report_mismatch("result_frame", 32'(out_result_frame), 32'(want.frame));
          if (out_present != want.present)
            report_mismatch("present", 32'(out_present), 32'(want.present));
          if (out_writable != want.writable)
            report_mismatch("writable", 32'(out_writable), 32'(want.writable));
          if (out_user_mode != want.user_mode)
            report_mismatch("user_mode", 32'(out_user_mode), 32'(want.user_mode));
          if (out_is_used != want.is_used)
            report_mismatch("is_used", 32'(out_is_used), 32'(want.is_used));
        end
      end
      idle = (hold_cycles != 0) ||
             (!(results_seen >= 150 && results_seen < 300) && ($urandom_range(99) < 27));
      out_ready <= !idle;
    end
  end

  // Long back-pressure on the result side, once, so the input stalls behind it.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cycles <= 0;
    end else if (!hold_done && results_seen == 60) begin
      hold_cycles <= 400;
      hold_done   <= 1'b1;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, outcome_q.size());
      $display("[frame_bitmap_allocator_top] ERROR");
      $finish;
    end
  end

  initial begin
    int total;
    int pick;
    int hi;
    int allocs;
    int f;

    // directed: reset state, attribute bits, skips, hole reuse, top frame
    add_request(fba_pkg::OP_TEST, 0, 0, 0);
    add_request(fba_pkg::OP_TEST, 4095, 1, 1);
    add_request(fba_pkg::OP_ALLOC, 0, 0, 1);
    add_request(fba_pkg::OP_ALLOC, 0, 1, 0);
    add_request(fba_pkg::OP_ALLOC, 0, 1, 1);
    add_request(fba_pkg::OP_ALLOC, 0, 0, 0);
    add_request(fba_pkg::OP_ALLOC, 5, 0, 1);
    add_request(fba_pkg::OP_ALLOC, 4095, 1, 1);
    add_request(fba_pkg::OP_FREE, 0, 1, 1);
    add_request(fba_pkg::OP_FREE, 1, 0, 0);
    add_request(fba_pkg::OP_TEST, 1, 0, 0);
    add_request(fba_pkg::OP_ALLOC, 0, 1, 1);
    add_request(fba_pkg::OP_MARK, 4095, 0, 0);
    add_request(fba_pkg::OP_TEST, 4095, 0, 0);
    add_request(fba_pkg::OP_MARK, 0, 1, 1);
    add_request(fba_pkg::OP_TEST, 2, 0, 1);
    add_request(fba_pkg::OP_FREE, 4095, 1, 0);
    add_request(fba_pkg::OP_TEST, 4095, 0, 0);
    add_request(fba_pkg::OP_FREE, 2048, 0, 1);
    add_request(fba_pkg::OP_TEST, 2048, 1, 0);
    add_request(fba_pkg::OP_MARK, 2730, 0, 0);
    add_request(fba_pkg::OP_TEST, 1365, 1, 1);

    // random: allocations land low, so frees and tests mostly aim there
    allocs = 5;
    for (int n = 0; n < 460; n++) begin
      pick = $urandom_range(99);
      hi = (allocs + 8 > 4095) ? 4095 : allocs + 8;
      if (pick < 35) begin
        f = ($urandom_range(99) < 80) ? 0 : $urandom_range(4095, 1);
        if (f == 0) allocs++;
        add_request(fba_pkg::OP_ALLOC, f, $urandom_range(1), $urandom_range(1));
      end else if (pick < 60) begin
        pick = $urandom_range(99);
        f = (pick < 70) ? $urandom_range(hi, 1) :
            (pick < 90) ? $urandom_range(4095) : 0;
        add_request(fba_pkg::OP_FREE, f, $urandom_range(1), $urandom_range(1));
      end else if (pick < 78) begin
        f = ($urandom_range(1) == 1) ? $urandom_range(hi) : $urandom_range(4095);
        add_request(fba_pkg::OP_MARK, f, $urandom_range(1), $urandom_range(1));
      end else begin
        f = ($urandom_range(99) < 60) ? $urandom_range(hi) : $urandom_range(4095);
        add_request(fba_pkg::OP_TEST, f, $urandom_range(1), $urandom_range(1));
      end
    end

    // closing mix of allocates, frees and tests, including the top frame
    add_request(fba_pkg::OP_ALLOC, 0, 0, 1);
    add_request(fba_pkg::OP_ALLOC, 77, 1, 0);
    f = $urandom_range(4094, 1);
    add_request(fba_pkg::OP_FREE, f, 0, 0);
    add_request(fba_pkg::OP_TEST, f, 1, 1);
    add_request(fba_pkg::OP_ALLOC, 0, 1, 1);
    add_request(fba_pkg::OP_ALLOC, 0, 0, 0);
    add_request(fba_pkg::OP_FREE, 4095, 1, 1);
    add_request(fba_pkg::OP_ALLOC, 0, 0, 1);
    add_request(fba_pkg::OP_TEST, 4095, 0, 0);
    total = request_q.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (requests_sent < total || outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (outcome_q.size() != 0)
      report_mismatch("results never delivered", outcome_q.size(), 0);

    $display("Covered %0d requests and checked %0d results, with a long output stall",
             total, results_seen);
    $display("Frames granted %0d, requests skipped %0d, refused as full %0d, mismatches %0d",
             grants, skips, refusals, mismatches);
    if (mismatches == 0) begin
      $display("[frame_bitmap_allocator_top] OK");
    end else begin
      $display("[frame_bitmap_allocator_top] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
sv/fba_pkg.sv
sv/frame_bitmap_allocator_top.sv
sim/testbench.sv
